/* hw/rtl/cfo_pkg.sv */
// cfo_pkg: shared constants and types of the circular fifo with overwrite
// sizes, operation and status codes, controller states; no dependencies
`default_nettype none

package cfo_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // beat field widths
    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 3'd0,
        OP_DEQ  = 3'd1,
        OP_PEEK = 3'd2,
        OP_SOFT = 3'd3,
        OP_HARD = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERWRITE_EN = 1'd0,
        CFG_ERASE_BYTE   = 1'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/circular_fifo_with_overwrite.sv */
// circular_fifo_with_overwrite: ring-buffer fifo with optional overwrite, top level
// holds the entry memory, pointers, controller and output register; uses cfo_pkg
`default_nettype none

// A 16-entry ring buffer of 32-bit words driven by operation beats on the s_ side
// (enqueue, dequeue, peek, soft clear, hard clear) and answering each operation with
// one result beat on the m_ side: status, data word, occupancy and full/empty flags.
// With overwrite enabled, an enqueue into a full queue replaces the oldest word.
// The words live in a synchronous memory with a registered read port, so an
// enqueue, a soft clear, an unused code or a dequeue or peek refused on an empty
// queue is answered from S_IDLE, a dequeue or peek of a non-empty queue passes
// through S_READ (address, then registered read data); a hard clear runs S_FILL,
// sweeping the memory one entry per cycle while s_tready stays low. The result
// register lets a new beat be taken in the cycle the previous result is taken.
// No clearing pass follows reset: entries are only read after they were written.
module circular_fifo_with_overwrite (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // operation channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // op[2:0], data_in[34:3], zero pad
    input  wire logic [cfo_pkg::S_TDATA_W-1:0]       s_tdata,
    // result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // status[1:0], data_out[33:2], occupancy[38:34], is_full[39], is_empty[40], zero pad
    output logic [cfo_pkg::M_TDATA_W-1:0]            m_tdata,
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [cfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cfo_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

    localparam int PW = cfo_pkg::PTR_W;
    localparam int CW = cfo_pkg::CNT_W;
    localparam int DW = cfo_pkg::DATA_WIDTH;
    localparam logic [PW-1:0] LAST_SLOT = PW'(cfo_pkg::CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(cfo_pkg::CAPACITY);

    // entry memory
    logic [DW-1:0] mem [cfo_pkg::CAPACITY];
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] rd_data_reg;

    // configuration
    logic                          overwrite_en_reg;
    logic [cfo_pkg::CFG_DAT_W-1:0] erase_byte_reg;

    // queue state
    cfo_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   fill_idx_reg, fill_idx_next;
    logic [DW-1:0]   fill_word_reg, fill_word_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    cfo_pkg::status_t         status_reg, status_next;
    logic [cfo_pkg::WORD_W-1:0] dout_reg, dout_next;
    logic [CW-1:0]            occ_reg, occ_next;

    logic                     in_beat;
    logic                     out_load;
    logic [cfo_pkg::OP_W-1:0] in_op;
    logic [DW-1:0]            in_data;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    assign in_op   = s_tdata[cfo_pkg::OP_W-1:0];
    assign in_data = DW'(s_tdata[cfo_pkg::OP_W +: cfo_pkg::WORD_W]);

    // one operation at a time; result register must be free or draining
    assign s_tready = (state_reg == cfo_pkg::S_IDLE) && (!m_valid_reg || m_tready);
    assign in_beat  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0,
                       (occ_reg == '0),
                       (occ_reg == FULL_CNT),
                       cfo_pkg::OCC_W'(occ_reg),
                       dout_reg,
                       status_reg};

    // controller: next state, pointer updates, memory write and result load
    always_comb begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        count_next     = count_reg;
        fill_idx_next  = fill_idx_reg;
        fill_word_next = fill_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = wptr_reg;
        mem_wdata      = in_data;
        out_load       = 1'b0;
        status_next    = status_reg;
        dout_next      = dout_reg;
        occ_next       = occ_reg;

        case (state_reg)
            cfo_pkg::S_IDLE: begin
                if (in_beat) begin
                    case (cfo_pkg::op_t'(in_op))
                        cfo_pkg::OP_ENQ: begin
                            out_load    = 1'b1;
                            dout_next   = '0;
                            status_next = cfo_pkg::ST_OK;
                            if (count_reg == FULL_CNT) begin
                                if (overwrite_en_reg) begin
                                    // replace the oldest word, both pointers move
                                    mem_we    = 1'b1;
                                    wptr_next = next_slot(wptr_reg);
                                    rptr_next = next_slot(rptr_reg);
                                end else begin
                                    status_next = cfo_pkg::ST_FULL;
                                end
                            end else begin
                                mem_we     = 1'b1;
                                wptr_next  = next_slot(wptr_reg);
                                count_next = count_reg + CW'(1);
                            end
                            occ_next = count_next;
                        end
                        cfo_pkg::OP_DEQ, cfo_pkg::OP_PEEK: begin
                            if (count_reg == '0) begin
                                out_load    = 1'b1;
                                status_next = cfo_pkg::ST_EMPTY;
                                dout_next   = '0;
                                occ_next    = count_reg;
                            end else begin
                                // memory reads rptr this edge; S_READ then loads the result register
                                state_next = cfo_pkg::S_READ;
                                if (cfo_pkg::op_t'(in_op) == cfo_pkg::OP_DEQ) begin
                                    rptr_next  = next_slot(rptr_reg);
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        cfo_pkg::OP_SOFT, cfo_pkg::OP_HARD: begin
                            out_load    = 1'b1;
                            status_next = cfo_pkg::ST_OK;
                            dout_next   = '0;
                            wptr_next   = '0;
                            rptr_next   = '0;
                            count_next  = '0;
                            occ_next    = '0;
                            if (cfo_pkg::op_t'(in_op) == cfo_pkg::OP_HARD) begin
                                state_next     = cfo_pkg::S_FILL;
                                fill_idx_next  = '0;
                                fill_word_next = {(DW / 8){erase_byte_reg}};
                            end
                        end
                        default: begin
                            // unused code: report current occupancy only
                            out_load    = 1'b1;
                            status_next = cfo_pkg::ST_OK;
                            dout_next   = '0;
                            occ_next    = count_reg;
                        end
                    endcase
                end
            end
            cfo_pkg::S_READ: begin
                out_load    = 1'b1;
                status_next = cfo_pkg::ST_OK;
                dout_next   = cfo_pkg::WORD_W'(rd_data_reg);
                occ_next    = count_reg;
                state_next  = cfo_pkg::S_IDLE;
            end
            cfo_pkg::S_FILL: begin
                mem_we        = 1'b1;
                mem_waddr     = fill_idx_reg;
                mem_wdata     = fill_word_reg;
                fill_idx_next = fill_idx_reg + PW'(1);
                if (fill_idx_reg == LAST_SLOT) begin
                    state_next = cfo_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cfo_pkg::S_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_tready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // entry memory: one write port, registered read at the read pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rptr_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cfo_pkg::S_IDLE;
            wptr_reg         <= '0;
            rptr_reg         <= '0;
            count_reg        <= '0;
            fill_idx_reg     <= '0;
            m_valid_reg      <= 1'b0;
            overwrite_en_reg <= 1'b0;
            erase_byte_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            count_reg    <= count_next;
            fill_idx_reg <= fill_idx_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfo_pkg::cfg_idx_t'(cfg_index))
                    cfo_pkg::CFG_OVERWRITE_EN: overwrite_en_reg <= cfg_wdata[0];
                    cfo_pkg::CFG_ERASE_BYTE:   erase_byte_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fill_word_reg <= fill_word_next;
        status_reg    <= status_next;
        dout_reg      <= dout_next;
        occ_reg       <= occ_next;
    end

endmodule

`default_nettype wire
